@@ rtl/scs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted coordinate set package
// Shared constants, opcodes and the control word that drives the cell row.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int SCS_CAPACITY = 64;
  localparam int COORD_W      = 16;
  localparam int KEY_W        = 2 * COORD_W;
  localparam int OP_W         = 2;
  localparam int TOTAL_W      = 7;

  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Flipping both sign bits makes unsigned order match signed (x, y) order.
  localparam logic [KEY_W-1:0] ORDER_FLIP = 32'h8000_8000;

  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             rem;
    logic             clr;
    logic [KEY_W-1:0] cmp_key;
    logic [KEY_W-1:0] ins_key;
  } scs_ctrl_t;

endpackage

@@ rtl/scs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted coordinate set cell
// Holds one ordered key, compares it with a request and shifts left or right.
// ----------------------------------------------------------------------------
module scs_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scs_pkg::scs_ctrl_t       ctrl,
  input  logic                     left_lt,
  input  logic                     left_valid,
  input  logic [scs_pkg::KEY_W-1:0] left_data,
  input  logic                     right_valid,
  input  logic [scs_pkg::KEY_W-1:0] right_data,
  output logic                     lt,
  output logic                     eq,
  output logic                     valid,
  output logic [scs_pkg::KEY_W-1:0] data
);
  import scs_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [KEY_W-1:0] data_r;
  logic [KEY_W-1:0] data_nxt;
  logic             lt_r;
  logic             eq_r;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.ins && !lt_r) begin
      if (left_lt) begin
        valid_nxt = 1'b1;
        data_nxt  = ctrl.ins_key;
      end else begin
        valid_nxt = left_valid;
        data_nxt  = left_data;
      end
    end else if (ctrl.rem && !lt_r) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctrl.cmp) begin
        lt_r <= valid_r && (data_r < ctrl.cmp_key);
        eq_r <= valid_r && (data_r == ctrl.cmp_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign lt    = lt_r;
  assign eq    = eq_r;
  assign valid = valid_r;
  assign data  = data_r;

endmodule

@@ rtl/sorted_coordinate_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted coordinate set
// Ordered set of signed (x, y) pairs kept in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one request word: an opcode (check, insert,
//   remove, clear) and a signed pair. The output channel returns one word per
//   request: whether the pair was present before, a full status for a refused
//   insert, and the number of stored pairs afterwards.
//   At acceptance every cell compares its entry with the pair and registers
//   the result. Once the output register is free, the row shifts in one
//   step, opening or closing a gap at the insertion point, and the result
//   word is registered together with the shift. A new request is taken only
//   after the current one has been applied, since the compare pass and the
//   shift pass through the cell row come one after the other.
//   Reset empties the set at once by clearing each cell's valid bit.
//   While the receiver stalls, the next request is still accepted and its
//   compare results are held; its shift waits until the pending word is
//   taken.
// ----------------------------------------------------------------------------
module sorted_coordinate_set #(
  parameter int CAPACITY = scs_pkg::SCS_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [scs_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [scs_pkg::COORD_W-1:0] in_key_x,
  input  logic signed [scs_pkg::COORD_W-1:0] in_key_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_was_present,
  output logic                              out_status,
  output logic [scs_pkg::TOTAL_W-1:0]       out_entry_total
);
  import scs_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {ST_IDLE, ST_APPLY} state_t;

  state_t              state_r;
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                was_r;
  logic                status_r;
  logic [TOTAL_W-1:0]  total_r;

  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;
  logic [KEY_W-1:0]    data_vec [CAPACITY];

  logic                accept;
  logic                apply;
  logic                found;
  logic                full;
  logic                do_ins;
  logic                do_rem;
  logic                do_clr;
  logic                refused;
  logic [CNT_W+TOTAL_W-1:0] total_ext;
  scs_ctrl_t           ctrl;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign apply    = (state_r == ST_APPLY) && (!out_valid_r || out_ready);
  assign found    = |eq_vec;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign do_clr   = apply && (op_r == OP_CLEAR);
  assign do_ins   = apply && (op_r == OP_INSERT) && !found && !full;
  assign do_rem   = apply && (op_r == OP_REMOVE) && found;
  assign refused  = (op_r == OP_INSERT) && !found && full;

  always_comb begin
    count_nxt = count_r;
    if (do_clr) begin
      count_nxt = '0;
    end else if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign total_ext = {{TOTAL_W{1'b0}}, count_nxt};

  always_comb begin
    ctrl.cmp     = accept;
    ctrl.ins     = do_ins;
    ctrl.rem     = do_rem;
    ctrl.clr     = do_clr;
    ctrl.cmp_key = {in_key_x, in_key_y} ^ ORDER_FLIP;
    ctrl.ins_key = key_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic             left_lt;
      logic             left_valid;
      logic [KEY_W-1:0] left_data;
      logic             right_valid;
      logic [KEY_W-1:0] right_data;

      if (gi == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_valid = 1'b0;
        assign left_data  = '0;
      end else begin : g_inner_left
        assign left_lt    = lt_vec[gi-1];
        assign left_valid = valid_vec[gi-1];
        assign left_data  = data_vec[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_valid = 1'b0;
        assign right_data  = '0;
      end else begin : g_inner_right
        assign right_valid = valid_vec[gi+1];
        assign right_data  = data_vec[gi+1];
      end

      scs_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .left_lt     (left_lt),
        .left_valid  (left_valid),
        .left_data   (left_data),
        .right_valid (right_valid),
        .right_data  (right_data),
        .lt          (lt_vec[gi]),
        .eq          (eq_vec[gi]),
        .valid       (valid_vec[gi]),
        .data        (data_vec[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (apply) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      key_r <= {in_key_x, in_key_y} ^ ORDER_FLIP;
    end
    if (apply) begin
      was_r    <= (op_r == OP_CLEAR) ? 1'b0 : found;
      status_r <= (op_r == OP_CLEAR) ? 1'b0 : refused;
      total_r  <= total_ext[TOTAL_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_present = was_r;
  assign out_status      = status_r;
  assign out_entry_total = total_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("entry count differs from occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("occupied cells are not a contiguous prefix");

  a_no_flags_for_clear: assert property (@(posedge clk) disable iff (!rst_n)
    apply && (op_r == OP_CLEAR) |=> !out_was_present && !out_status
      && (out_entry_total == '0))
    else $error("clear produced a nonzero result word");

endmodule
